### rtl/sscp_pkg.sv
// Shared types and constants for the serial send command parser.
// Used by the front end, the command queue, the back end and the top level.
package sscp_pkg;

  // Payload buffer depth and derived widths
  localparam int BUF_SIZE = 64;
  localparam int LEN_W    = $clog2(BUF_SIZE);
  localparam int SUM_W    = LEN_W + 4;

  // Command queue depth and derived widths
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);

  // Character constants
  localparam logic [7:0] PORT_CHAR_RST = 8'd50;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam int         DEC_BASE      = 10;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_PORT = 2'd1,
    EV_SIZE = 2'd2,
    EV_BYTE = 2'd3
  } ev_t;

  // One queued command: a single result, or a payload release of len bytes
  typedef struct packed {
    logic             drain;
    ev_t              ev;
    logic [7:0]       value;
    logic             hook;
    logic [LEN_W-1:0] len;
  } ssc_entry_t;

  // Status from back end to front end
  typedef struct packed {
    logic drain_done;
  } ssc_back_st_t;

endpackage

### rtl/serial_send_command_parser_core.sv
// Top level of the serial send command parser: front end, command queue,
// back end and payload buffer. Depends on sscp_pkg and all sscp_ modules.
//
//  Channel  Direction  Handshake            Payload
//  in_      slave      in_tvalid/in_tready  in_tdata: rx_char
//  out_     master     out_tvalid/tready    tdata: value, hook_active; tuser:
//                                           event_res; tlast: last
//  cfg_     write      cfg_wr_en            cfg_wr_data: port_char
//
// A byte that does not finish a payload is accepted every cycle while in_tready
// is high, and gives its result through a queue slot and then the output register.
// The final payload byte releases length results, each read in S_RD by the
// registered read of the payload buffer and loaded into the output register in S_LOAD.
// Payload bytes of the next command stall at in_tready until that release
// has read its last byte; all other bytes keep flowing while the queue has room.
// Reset (synchronous, active low) clears phase, counters, queue and port_char
// (back to '2'); the payload buffer is not cleared.
module serial_send_command_parser_core
  import sscp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // [7:0] port_char
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] rx_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [7:0] value, [8] hook_active, [15:9] zero
  output logic [1:0]  out_tuser,     // [1:0] event_res
  output logic        out_tlast
);

  logic             q_push, q_ready, q_pop, q_head_valid;
  ssc_entry_t       q_entry, q_head;
  logic             wr_en, rd_en;
  logic [LEN_W-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;
  ssc_back_st_t     back_st;
  ev_t              out_ev;
  logic [7:0]       out_value;
  logic             out_hook;

  sscp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_char     (in_tdata),
    .q_push      (q_push),
    .q_entry     (q_entry),
    .q_ready     (q_ready),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .back_st     (back_st)
  );

  sscp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  sscp_ram #(
    .WIDTH (8),
    .DEPTH (BUF_SIZE)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sscp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .back_st    (back_st),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_ev     (out_ev),
    .out_value  (out_value),
    .out_last   (out_tlast),
    .out_hook   (out_hook)
  );

  // Pack result fields
  assign out_tdata = {7'd0, out_hook, out_value};
  assign out_tuser = out_ev;

endmodule

### rtl/sscp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sscp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/sscp_front.sv
// Front end: accepts command bytes, tracks the parse phase and length,
// writes payload bytes to the buffer and queues one command per byte.
// Depends on sscp_pkg.
module sscp_front
  import sscp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_char,
  output logic             q_push,
  output ssc_entry_t       q_entry,
  input  logic             q_ready,
  output logic             wr_en,
  output logic [LEN_W-1:0] wr_addr,
  output logic [7:0]       wr_data,
  input  ssc_back_st_t     back_st
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] length_r, length_nxt;
  logic [LEN_W-1:0] rcv_cnt_r, rcv_cnt_nxt;
  logic [7:0]       port_char_r, port_char_nxt;
  logic             drain_pend_r, drain_pend_nxt;

  logic             accept;
  logic             is_digit;
  logic [3:0]       digit;
  logic [SUM_W-1:0] sum;
  logic [LEN_W:0]   cnt_inc;

  // Hold payload bytes back while an earlier payload is still being read out
  assign in_tready = q_ready && !((phase_r == PH_DATA) && drain_pend_r);
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept;

  assign is_digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign digit    = 4'(in_char - CH_ZERO);
  assign sum      = {{(SUM_W-LEN_W){1'b0}}, length_r} * SUM_W'(DEC_BASE)
                    + SUM_W'(digit);
  assign cnt_inc  = {1'b0, rcv_cnt_r} + (LEN_W+1)'(1);

  // Payload store write
  assign wr_en   = accept && (phase_r == PH_DATA);
  assign wr_addr = rcv_cnt_r;
  assign wr_data = in_char;

  // Parse one byte
  always_comb begin
    phase_nxt      = phase_r;
    length_nxt     = length_r;
    rcv_cnt_nxt    = rcv_cnt_r;
    port_char_nxt  = cfg_wr_en ? cfg_wr_data : port_char_r;
    drain_pend_nxt = drain_pend_r && !back_st.drain_done;
    q_entry        = '{drain: 1'b0, ev: EV_NONE, value: 8'd0, hook: 1'b1,
                       len: '0};
    case (phase_r)
      PH_LEN: begin
        if (is_digit) begin
          if (sum < SUM_W'(BUF_SIZE)) begin
            if (accept) length_nxt = LEN_W'(sum);
          end else begin
            q_entry.ev   = EV_SIZE;
            q_entry.hook = 1'b0;
            if (accept) phase_nxt = PH_IDLE;
          end
        end else if (length_r != '0) begin
          if (accept) begin
            rcv_cnt_nxt = '0;
            phase_nxt   = PH_DATA;
          end
        end else begin
          q_entry.hook = 1'b0;
          if (accept) phase_nxt = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (cnt_inc >= {1'b0, length_r}) begin
          q_entry.drain = 1'b1;
          q_entry.ev    = EV_BYTE;
          q_entry.hook  = 1'b0;
          q_entry.len   = length_r;
          if (accept) begin
            phase_nxt      = PH_IDLE;
            drain_pend_nxt = 1'b1;
          end
        end
        if (accept) rcv_cnt_nxt = LEN_W'(cnt_inc);
      end
      default: begin
        // idle, and the unused phase code acts as idle
        if (in_char == port_char_r) begin
          if (accept) begin
            length_nxt = '0;
            phase_nxt  = PH_LEN;
          end
        end else begin
          q_entry.ev    = EV_PORT;
          q_entry.value = in_char;
          q_entry.hook  = 1'b0;
          if (accept) phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      length_r     <= '0;
      rcv_cnt_r    <= '0;
      port_char_r  <= PORT_CHAR_RST;
      drain_pend_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      length_r     <= length_nxt;
      rcv_cnt_r    <= rcv_cnt_nxt;
      port_char_r  <= port_char_nxt;
      drain_pend_r <= drain_pend_nxt;
    end
  end

  // The buffer is never written while a release is pending
  a_no_wr_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !drain_pend_r)
    else $error("payload write during pending release");

  // A queued release marks the buffer busy
  a_drain_sets_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_entry.drain) |=> drain_pend_r)
    else $error("release queued without pending flag");

endmodule

### rtl/sscp_queue.sv
// Short command queue between the front and back ends.
// Depends on sscp_pkg.
module sscp_queue
  import sscp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ssc_entry_t push_entry,
  output logic       push_ready,
  input  logic       pop,
  output ssc_entry_t head,
  output logic       head_valid
);

  ssc_entry_t      slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, wptr_nxt;
  logic [Q_AW-1:0] rptr_r, rptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != Q_CW'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt  = do_push ? Q_AW'(wptr_r + Q_AW'(1)) : wptr_r;
    rptr_nxt  = do_pop  ? Q_AW'(rptr_r + Q_AW'(1)) : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + Q_CW'(1);
    if (do_pop && !do_push) count_nxt = count_r - Q_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("queue occupancy out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wptr_r == rptr_r))
    else $error("empty queue with unequal pointers");

endmodule

### rtl/sscp_back.sv
// Back end: pops queued commands and drives the output register; a release
// command reads the payload buffer one byte at a time.
// Depends on sscp_pkg.
module sscp_back
  import sscp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ssc_entry_t       head,
  input  logic             head_valid,
  output logic             pop,
  output logic             rd_en,
  output logic [LEN_W-1:0] rd_addr,
  input  logic [7:0]       rd_data,
  output ssc_back_st_t     back_st,
  output logic             out_valid,
  input  logic             out_ready,
  output ev_t              out_ev,
  output logic [7:0]       out_value,
  output logic             out_last,
  output logic             out_hook
);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD   = 2'd1,
    S_LOAD = 2'd2
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] num_r, num_nxt;
  logic             out_valid_r, out_valid_nxt;
  ev_t              out_ev_r, out_ev_nxt;
  logic [7:0]       out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_hook_r, out_hook_nxt;

  logic             out_free;
  logic             byte_last;

  assign out_free  = !out_valid_r || out_ready;
  assign byte_last = (({1'b0, cnt_r} + (LEN_W+1)'(1)) == {1'b0, num_r});
  assign rd_addr   = cnt_r;

  // Sequence commands and payload reads
  always_comb begin
    state_nxt          = state_r;
    cnt_nxt            = cnt_r;
    num_nxt            = num_r;
    pop                = 1'b0;
    rd_en              = 1'b0;
    back_st.drain_done = 1'b0;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_ev_nxt         = out_ev_r;
    out_value_nxt      = out_value_r;
    out_last_nxt       = out_last_r;
    out_hook_nxt       = out_hook_r;
    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          if (head.drain) begin
            pop       = 1'b1;
            cnt_nxt   = '0;
            num_nxt   = head.len;
            state_nxt = S_RD;
          end else if (out_free) begin
            pop           = 1'b1;
            out_valid_nxt = 1'b1;
            out_ev_nxt    = head.ev;
            out_value_nxt = head.value;
            out_last_nxt  = 1'b1;
            out_hook_nxt  = head.hook;
          end
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = EV_BYTE;
          out_value_nxt = rd_data;
          out_last_nxt  = byte_last;
          out_hook_nxt  = 1'b0;
          if (byte_last) begin
            back_st.drain_done = 1'b1;
            state_nxt          = S_IDLE;
          end else begin
            cnt_nxt   = LEN_W'(cnt_r + LEN_W'(1));
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      num_r       <= '0;
      out_valid_r <= 1'b0;
      out_ev_r    <= EV_NONE;
      out_value_r <= 8'd0;
      out_last_r  <= 1'b0;
      out_hook_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      num_r       <= num_nxt;
      out_valid_r <= out_valid_nxt;
      out_ev_r    <= out_ev_nxt;
      out_value_r <= out_value_nxt;
      out_last_r  <= out_last_nxt;
      out_hook_r  <= out_hook_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ev    = out_ev_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_hook  = out_hook_r;

  // Buffer data is only consumed after a read was issued, held while the output is busy
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> ($past(state_r) == S_RD || $past(state_r) == S_LOAD))
    else $error("load without preceding read");

  // The read index stays inside the released run
  a_cnt_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_LOAD) |-> (cnt_r < num_r))
    else $error("payload read index beyond run length");

endmodule
